// ===== sv/md5_pkg.sv =====
`timescale 1ns / 1ps
package md5_pkg;

    localparam logic [31:0] C_IV_A = 32'h67452301;
    localparam logic [31:0] C_IV_B = 32'hEFCDAB89;
    localparam logic [31:0] C_IV_C = 32'h98BADCFE;
    localparam logic [31:0] C_IV_D = 32'h10325476;

    localparam logic [31:0] C_PAD_BYTE = 32'h0000_0080;

    localparam logic [31:0] C_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] C_SHIFT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LENLO,
        S_LENHI,
        S_CPRE,
        S_CRND,
        S_CFIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        SRC_IN,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN_LO,
        SRC_LEN_HI
    } t_src;

    typedef struct packed {
        logic       init;     // back to initial chaining values, empty message
        logic       put;      // pack bytes from src into the block
        t_src       src;
        logic       load;     // working regs <= chaining words
        logic       pre;      // fetch K + M for pre_rnd
        logic [5:0] pre_rnd;
        logic       round;    // run one round
        logic [5:0] rnd;
        logic       fin;      // chaining words += working regs
    } t_dp_cmd;

    typedef struct packed {
        logic fills;     // current put completes word 15
        logic pad_done;  // at byte 56 of the block
    } t_dp_sts;

    // message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] r4;
        logic [3:0] res;
        r4 = r[3:0];
        unique case (r[5:4])
            2'd0:    res = r4;
            2'd1:    res = 4'(r4 * 4'd5 + 4'd1);
            2'd2:    res = 4'(r4 * 4'd3 + 4'd5);
            default: res = 4'(r4 * 4'd7);
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    // keep the low n bytes of a word
    function automatic logic [31:0] byte_keep(input logic [31:0] x, input logic [2:0] n);
        logic [31:0] res;
        for (int k = 0; k < 4; k++) begin
            res[8*k +: 8] = (3'(k) < n) ? x[8*k +: 8] : 8'h00;
        end
        return res;
    endfunction

endpackage

// ===== sv/md5_if.sv =====
`timescale 1ns / 1ps
interface md5_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;

    modport source (output valid, output data_word, output valid_bytes, output last,
                    input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input last,
                    output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source (output valid, output digest_low, output digest_high, input ready);
    modport sink   (input valid, input digest_low, input digest_high, output ready);
endinterface

// ===== sv/md5_dp.sv =====
`timescale 1ns / 1ps
module md5_dp
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    output t_dp_sts     o_sts,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);

    logic [31:0] r_chain [4];
    logic [31:0] r_blk [16];
    logic [31:0] r_acc;
    logic [3:0]  r_wp;
    logic [1:0]  r_bp;
    logic [63:0] r_bits;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_km;

    logic [31:0] src_data;
    logic [2:0]  src_cnt;
    logic [2:0]  in_cnt;
    logic [63:0] packed_bytes;
    logic [2:0]  fill;
    logic        word_full;
    logic [31:0] mix;
    logic [31:0] rot_in;
    logic [31:0] n_b;

    assign in_cnt = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;

    always_comb begin
        unique case (i_cmd.src)
            SRC_IN: begin
                src_data = i_data_word;
                src_cnt  = in_cnt;
            end
            SRC_PAD: begin
                src_data = C_PAD_BYTE;
                src_cnt  = 3'd1;
            end
            SRC_ZERO: begin
                src_data = '0;
                src_cnt  = 3'd4 - {1'b0, r_bp};
            end
            SRC_LEN_LO: begin
                src_data = r_bits[31:0];
                src_cnt  = 3'd4;
            end
            SRC_LEN_HI: begin
                src_data = r_bits[63:32];
                src_cnt  = 3'd4;
            end
            default: begin
                src_data = '0;
                src_cnt  = 3'd0;
            end
        endcase
    end

    // held bytes below, new bytes placed after them
    assign packed_bytes = {32'h0, byte_keep(r_acc, {1'b0, r_bp})}
                        | ({32'h0, byte_keep(src_data, src_cnt)} << {r_bp, 3'b000});
    assign fill      = {1'b0, r_bp} + src_cnt;
    assign word_full = fill[2];

    assign o_sts.fills    = i_cmd.put && word_full && (r_wp == 4'd15);
    assign o_sts.pad_done = (r_wp == 4'd14) && (r_bp == 2'd0);

    always_comb begin
        unique case (i_cmd.rnd[5:4])
            2'd0:    mix = (r_b & r_c) | (~r_b & r_d);
            2'd1:    mix = (r_d & r_b) | (~r_d & r_c);
            2'd2:    mix = r_b ^ r_c ^ r_d;
            default: mix = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign rot_in = r_a + mix + r_km;
    assign n_b    = r_b + rotl32(rot_in, C_SHIFT[{i_cmd.rnd[5:4], i_cmd.rnd[1:0]}]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '{C_IV_A, C_IV_B, C_IV_C, C_IV_D};
            r_wp    <= '0;
            r_bp    <= '0;
            r_bits  <= '0;
        end else begin
            if (i_cmd.init) begin
                r_chain <= '{C_IV_A, C_IV_B, C_IV_C, C_IV_D};
                r_wp    <= '0;
                r_bp    <= '0;
                r_bits  <= '0;
            end
            if (i_cmd.put) begin
                r_bp <= fill[1:0];
                if (word_full) begin
                    r_wp <= r_wp + 4'd1;
                end
                if (i_cmd.src == SRC_IN) begin
                    r_bits <= r_bits + {58'h0, in_cnt, 3'b000};
                end
            end
            if (i_cmd.fin) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_acc <= word_full ? packed_bytes[63:32] : packed_bytes[31:0];
            if (word_full) begin
                r_blk[r_wp] <= packed_bytes[31:0];
            end
        end
        if (i_cmd.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= n_b;
        end
        if (i_cmd.pre) begin
            r_km <= C_K[i_cmd.pre_rnd] + r_blk[msg_index(i_cmd.pre_rnd)];
        end
    end

    assign o_digest_low  = {r_chain[1], r_chain[0]};
    assign o_digest_high = {r_chain[3], r_chain[2]};

    a_put_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> !i_cmd.put && !i_cmd.fin)
        else $error("put or finalize during a round");

    a_len_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && (i_cmd.src == SRC_LEN_LO || i_cmd.src == SRC_LEN_HI))
        |-> (r_bp == 2'd0))
        else $error("length written off a word boundary");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.init |=> (r_wp == 4'd0) && (r_bp == 2'd0) && (r_bits == 64'h0))
        else $error("init did not clear the position");

endmodule

// ===== sv/md5_ctrl.sv =====
`timescale 1ns / 1ps
module md5_ctrl
    import md5_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [5:0] r_rnd, n_rnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_rnd   <= n_rnd;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_ret         = r_ret;
        n_rnd         = r_rnd;
        o_cmd         = '0;
        o_cmd.src     = SRC_IN;
        o_cmd.rnd     = r_rnd;
        o_cmd.pre_rnd = r_rnd + 6'd1;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.put = 1'b1;
                    if (i_sts.fills) begin
                        n_state = S_CPRE;
                        n_ret   = i_in_last ? S_PAD80 : S_IDLE;
                    end else begin
                        n_state = i_in_last ? S_PAD80 : S_IDLE;
                    end
                end
            end
            S_PAD80: begin
                o_cmd.put = 1'b1;
                o_cmd.src = SRC_PAD;
                if (i_sts.fills) begin
                    n_state = S_CPRE;
                    n_ret   = S_PADZ;
                end else begin
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_sts.pad_done) begin
                    n_state = S_LENLO;
                end else begin
                    o_cmd.put = 1'b1;
                    o_cmd.src = SRC_ZERO;
                    if (i_sts.fills) begin
                        n_state = S_CPRE;
                        n_ret   = S_PADZ;
                    end
                end
            end
            S_LENLO: begin
                o_cmd.put = 1'b1;
                o_cmd.src = SRC_LEN_LO;
                n_state   = S_LENHI;
            end
            S_LENHI: begin
                o_cmd.put = 1'b1;
                o_cmd.src = SRC_LEN_HI;
                n_state   = S_CPRE;
                n_ret     = S_OUT;
            end
            S_CPRE: begin
                o_cmd.load    = 1'b1;
                o_cmd.pre     = 1'b1;
                o_cmd.pre_rnd = 6'd0;
                n_rnd         = 6'd0;
                n_state       = S_CRND;
            end
            S_CRND: begin
                o_cmd.round = 1'b1;
                o_cmd.pre   = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.fin = 1'b1;
                n_state   = r_ret;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.init = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a digest is offered");

    a_pre_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CPRE) |=> (r_state == S_CRND) && (r_rnd == 6'd0))
        else $error("compression did not start at round zero");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRND) && (r_rnd == 6'd63) |=> (r_state == S_CFIN))
        else $error("round 63 not followed by the chaining add");

    a_fills_goes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.fills |=> (r_state == S_CPRE))
        else $error("full block not compressed");

endmodule

// ===== sv/md5_digest_engine.sv =====
`timescale 1ns / 1ps
// A word that leaves its block open is packed and the engine is ready again; a word that closes a
// 64-byte block is packed, then preload, 64 rounds on the one shared round unit, and the add.
// Input is not accepted while a block is compressed (ready is high only in idle).
// Last word: padding and length are packed, and each block run after it (one or two) is
// compressed; the digest is held until taken, then initial chaining values.
// Reset (synchronous, active low): initial chaining values, empty message, idle.
module md5_digest_engine
    import md5_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    md5_in_if.sink     i_data,
    md5_out_if.source  o_digest
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: packs input beats, walks padding (0x80, zero fill, 64-bit
    // length), sequences 64 rounds per block and holds the digest beat.
    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_data.valid),
        .i_in_last   (i_data.last),
        .o_in_ready  (i_data.ready),
        .o_out_valid (o_digest.valid),
        .i_out_ready (o_digest.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: byte packer, 16-word block buffer, round unit with the
    // K + M sum registered in the cycle before its round, chaining words.
    md5_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_word   (i_data.data_word),
        .i_valid_bytes (i_data.valid_bytes),
        .o_sts         (sts),
        .o_digest_low  (o_digest.digest_low),
        .o_digest_high (o_digest.digest_high)
    );

endmodule
